### rtl/bicycle_model_pose_step_macros.svh
// ----------------------------------------------------------------------------
// Bicycle model pose step: assertion macros
// Shared assertion forms used by the RTL of the pose step block.
// ----------------------------------------------------------------------------
`ifndef BICYCLE_MODEL_POSE_STEP_MACROS_SVH
`define BICYCLE_MODEL_POSE_STEP_MACROS_SVH

// implication checked on every edge outside reset
`define BMPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define BMPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/bmps_pkg.sv
// ----------------------------------------------------------------------------
// Bicycle model pose step package
// Types and constants shared by the pose step block.
// ----------------------------------------------------------------------------
package bmps_pkg;

  localparam int unsigned CFG_ADDR_W = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TIME_STEP     = 3'd0,
    REG_INV_WHEELBASE = 3'd4
  } reg_addr_t;

  localparam logic signed [63:0] CORDIC_X0  = 64'sd652032874;
  localparam logic [31:0]        RAD_TO_BAM = 32'd683565276;
  localparam logic [31:0]        TAN_MAX    = 32'h7FFF_FFFF;
  localparam logic [15:0]        TIME_STEP_RST = 16'd6554;
  localparam logic [15:0]        INV_WB_RST    = 16'd1638;

  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;  default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

### rtl/bmps_stream_if.sv
// ----------------------------------------------------------------------------
// Bicycle model pose step: stream interfaces
// Valid/ready channels for the request and the result.
// ----------------------------------------------------------------------------
interface bmps_req_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] speed;
  logic signed [14:0] steer_angle;
  modport source (output valid, output speed, output steer_angle, input ready);
  modport sink   (input valid, input speed, input steer_angle, output ready);
endinterface

interface bmps_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [31:0] heading;
  modport source (output valid, output pos_x, output pos_y, output heading, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface

### rtl/bicycle_model_pose_step.sv
// Each request runs a CORDIC pass on the heading, the position update, a
// CORDIC pass on the steering angle, a 48-step restoring divide for the
// tangent and shared multiplier steps for the heading change. One request is
// taken at a time, as the CORDIC stage and the serial divider are shared; not
// ready while busy or while a result waits.
// Reset (rst_n low, synchronous) clears pose to zero and loads default
// time_step 6554 and inv_wheelbase 1638.
// ----------------------------------------------------------------------------
// Bicycle model pose step
// Advances an (x, y, heading) pose by one Euler step of the bicycle model.
// ----------------------------------------------------------------------------
module bicycle_model_pose_step #(
  parameter int CORDIC_STEPS  = 24,
  parameter int POS_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bmps_req_if.sink                    in_ch,
  bmps_res_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [bmps_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import bmps_pkg::*;
  `include "bicycle_model_pose_step_macros.svh"

  localparam int SH     = 54 - POS_FRAC_BITS;
  localparam int CSTEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int DIV_N  = 48;

  typedef enum logic [3:0] {
    S_IDLE, S_HC_INIT, S_CORDIC, S_POS, S_POS2, S_SC_INIT, S_DIV_INIT, S_DIV,
    S_B, S_C, S_DH, S_DH2, S_OUT
  } state_t;

  state_t state_r;
  logic [15:0] time_step_r, inv_wb_r;
  logic signed [31:0] x_r, y_r;
  logic [31:0] h_r;
  logic signed [14:0] steer_r;
  logic signed [63:0] cx_r, cy_r, cz_r;
  logic flip_r, second_r;
  logic [5:0] cnt_r;
  logic signed [31:0] a_r;
  logic signed [63:0] hc_r, hs_r, ss_r;
  logic [47:0] dq_r;
  logic [48:0] drem_r;
  logic [47:0] dden_r;
  logic [31:0] tan_r;
  logic [63:0] acc_r;
  logic [31:0] bm_r;
  logic [31:0] mh_r;
  logic out_valid_r;

  logic signed [63:0] cx_nxt, cy_nxt, cz_nxt;
  logic [31:0] ang_w;
  logic ang_flip;
  logic [31:0] ma, mt;
  logic [63:0] prod;
  logic signed [34:0] sum_w;
  logic [48:0] rem_sh;
  logic signed [14:0] steer_clamped;

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // CORDIC iteration
  always_comb begin
    if (!cz_r[63]) begin
      cx_nxt = cx_r - (cy_r >>> cnt_r);
      cy_nxt = cy_r + (cx_r >>> cnt_r);
      cz_nxt = cz_r - $signed({32'd0, atan_bam(cnt_r[4:0])});
    end else begin
      cx_nxt = cx_r + (cy_r >>> cnt_r);
      cy_nxt = cy_r - (cx_r >>> cnt_r);
      cz_nxt = cz_r + $signed({32'd0, atan_bam(cnt_r[4:0])});
    end
  end

  assign steer_clamped = (steer_r == -15'sd16384) ? -15'sd16383 : steer_r;

  always_comb begin
    if (state_r == S_HC_INIT) begin
      ang_w = h_r;
    end else begin
      ang_w = {steer_clamped[14], steer_clamped, 16'd0};
    end
    ang_flip = (ang_w > 32'h4000_0000) && (ang_w < 32'hC000_0000);
  end

  // shared multiplier operands
  always_comb begin
    ma = 32'(mag(64'(a_r)));
    mt = '0;
    case (state_r)
      S_POS:  mt = 32'(mag(hc_r));
      S_POS2: mt = 32'(mag(hs_r));
      S_B:    mt = {16'd0, inv_wb_r};
      S_C:    mt = tan_r;
      S_DH:   mt = RAD_TO_BAM;
      S_DH2:  mt = RAD_TO_BAM;
      default: mt = '0;
    endcase
    case (state_r)
      S_C:   ma = bm_r;
      S_DH:  ma = acc_r[63:32];
      S_DH2: ma = acc_r[31:0];
      default: ;
    endcase
    prod = ma * mt;
  end

  always_comb begin
    logic [63:0] d;
    logic signed [63:0] r;
    d = (prod + (64'd1 << (SH - 1))) >> SH;
    if ((state_r == S_POS ? (a_r[31] != hc_r[63]) : (a_r[31] != hs_r[63]))) begin
      r = (state_r == S_POS ? 64'(x_r) : 64'(y_r)) - $signed(d);
    end else begin
      r = (state_r == S_POS ? 64'(x_r) : 64'(y_r)) + $signed(d);
    end
    if (r > 64'sd2147483647) sum_w = 35'sd2147483647;
    else if (r < -64'sd2147483648) sum_w = -35'sd2147483648;
    else sum_w = r[34:0];
  end

  assign rem_sh = {drem_r[47:0], dq_r[47]};

  assign in_ch.ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.pos_x = x_r;
  assign out_ch.pos_y = y_r;
  assign out_ch.heading = h_r;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr)
      REG_TIME_STEP:     cfg_prdata = {16'd0, time_step_r};
      REG_INV_WHEELBASE: cfg_prdata = {16'd0, inv_wb_r};
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      time_step_r <= TIME_STEP_RST;
      inv_wb_r    <= INV_WB_RST;
      x_r         <= '0;
      y_r         <= '0;
      h_r         <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      second_r    <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        case (cfg_paddr)
          REG_TIME_STEP:     time_step_r <= cfg_pwdata[15:0];
          REG_INV_WHEELBASE: inv_wb_r    <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            steer_r  <= in_ch.steer_angle;
            a_r      <= 32'(in_ch.speed) * $signed({16'd0, time_step_r});
            second_r <= 1'b0;
            state_r  <= S_HC_INIT;
          end
        end
        S_HC_INIT, S_SC_INIT: begin
          cx_r   <= CORDIC_X0;
          cy_r   <= '0;
          flip_r <= ang_flip;
          cz_r   <= 64'($signed(ang_flip ? ang_w + 32'h8000_0000 : ang_w));
          cnt_r  <= '0;
          state_r <= S_CORDIC;
        end
        S_CORDIC: begin
          cx_r <= cx_nxt;
          cy_r <= cy_nxt;
          cz_r <= cz_nxt;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(CSTEPS - 1)) begin
            if (!second_r) begin
              hc_r <= flip_r ? -cx_nxt : cx_nxt;
              hs_r <= flip_r ? -cy_nxt : cy_nxt;
              state_r <= S_POS;
            end else begin
              hc_r <= flip_r ? -cx_nxt : cx_nxt;
              ss_r <= flip_r ? -cy_nxt : cy_nxt;
              state_r <= S_DIV_INIT;
            end
          end
        end
        S_POS: begin
          x_r <= sum_w[31:0];
          state_r <= S_POS2;
        end
        S_POS2: begin
          y_r <= sum_w[31:0];
          second_r <= 1'b1;
          state_r <= S_SC_INIT;
        end
        S_DIV_INIT: begin
          dq_r   <= {32'(mag(ss_r)), 16'd0};
          dden_r <= hc_r[47:0];
          drem_r <= '0;
          cnt_r  <= '0;
          state_r <= S_DIV;
          if (hc_r[63] || hc_r == 64'sd0) begin
            tan_r <= (ss_r == 64'sd0) ? 32'd0 : TAN_MAX;
            state_r <= S_B;
          end
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, dden_r}) begin
            drem_r <= rem_sh - {1'b0, dden_r};
            dq_r   <= {dq_r[46:0], 1'b1};
          end else begin
            drem_r <= rem_sh;
            dq_r   <= {dq_r[46:0], 1'b0};
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(DIV_N - 1)) state_r <= S_B;
        end
        S_B: begin
          if (!(hc_r[63] || hc_r == 64'sd0)) begin
            tan_r <= (dq_r > 48'(TAN_MAX)) ? TAN_MAX : dq_r[31:0];
          end
          bm_r <= 32'((prod + 64'd524288) >> 20);
          state_r <= S_C;
        end
        S_C: begin
          acc_r <= prod;
          state_r <= S_DH;
        end
        S_DH: begin
          mh_r <= prod[31:0];
          state_r <= S_DH2;
        end
        S_DH2: begin
          if (a_r[31] != ss_r[63]) begin
            h_r <= h_r - (mh_r + 32'((prod + 64'h8000_0000) >> 32));
          end else begin
            h_r <= h_r + (mh_r + 32'((prod + 64'h8000_0000) >> 32));
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `BMPS_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_r != S_IDLE, !in_ch.ready)
  `BMPS_ASSERT_NEXT(a_out_after_done, clk, rst_n, state_r == S_OUT, out_valid_r)
  `BMPS_ASSERT_IMPL(a_cordic_cnt, clk, rst_n, state_r == S_CORDIC, cnt_r < 6'(CSTEPS))
  `BMPS_ASSERT_NEXT(a_hold_out, clk, rst_n, out_valid_r && !out_ch.ready,
                    out_valid_r && $stable(h_r))
endmodule

### verif/bicycle_model_pose_step_test.sv
// ----------------------------------------------------------------------------
// Bicycle model pose step testbench
// Streams speed and steering requests into the pose step block under random
// stalls on both channels. Each result pose is checked field by field against
// a fixed-point model of the Euler step. The model covers the CORDIC
// sine and cosine, the tangent divide, saturating positions and the wrapping
// heading. Time step and reciprocal wheelbase are reprogrammed between phases.
// ----------------------------------------------------------------------------
module bicycle_model_pose_step_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bmps_pkg::*;

  typedef struct packed {
    logic signed [15:0] speed;
    logic signed [14:0] steer;
  } motion_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [31:0] hdg;
  } pose_t;

  localparam int STEPS = 24;
  localparam int FRAC  = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  bmps_req_if req_ch ();
  bmps_res_if res_ch ();

  bicycle_model_pose_step #(.CORDIC_STEPS(STEPS), .POS_FRAC_BITS(FRAC)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(req_ch.sink), .out_ch(res_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  motion_t pending_motion[$];
  pose_t   expected_pose[$];
  logic [15:0] dt_q016, inv_wb_q412;
  logic signed [31:0] pose_x, pose_y;
  logic [31:0] pose_hdg;
  int errors = 0, poses_seen = 0, sent = 0;
  bit calm = 1'b0;
  int drive_gap = 0, sink_gap = 0;

  function automatic logic signed [63:0] asr(logic signed [63:0] v, int s);
    return v >>> s;
  endfunction

  function automatic logic [63:0] mag(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  task automatic rotate(input logic [31:0] ang, output logic signed [63:0] c,
                        output logic signed [63:0] s);
    logic signed [63:0] x, y, z, dx, dy;
    logic [31:0] tbl [32];
    bit flip;
    tbl = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
            32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
            32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
            32'h00000001, 32'h00000000};
    flip = 1'b0;
    x = 64'sd652032874;
    y = 0;
    if (ang > 32'h40000000 && ang < 32'hC0000000) begin
      ang = ang + 32'h80000000;
      flip = 1'b1;
    end
    z = $signed({{32{ang[31]}}, ang});
    for (int i = 0; i < STEPS; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - $signed({32'd0, tbl[i]});
      end else begin
        x = x + dx; y = y - dy; z = z + $signed({32'd0, tbl[i]});
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic signed [31:0] shift_pos(logic signed [31:0] p,
      logic signed [63:0] a, logic signed [63:0] t);
    logic [63:0] m;
    logic signed [63:0] d, r;
    m = mag(a) * mag(t);
    d = $signed((m + (64'd1 << (53 - FRAC))) >> (54 - FRAC));
    if ((a < 0) != (t < 0)) d = -d;
    r = 64'(p) + d;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  task automatic euler_step(input motion_t m);
    logic signed [63:0] v, st, hc, hs, sc, ss, a;
    logic [63:0] tanm, bm, cm, dh;
    v = m.speed;
    st = m.steer;
    if (st < -16383) st = -16383;
    rotate(pose_hdg, hc, hs);
    a = v * $signed({48'd0, dt_q016});
    pose_x = shift_pos(pose_x, a, hc);
    pose_y = shift_pos(pose_y, a, hs);
    rotate(32'(st) << 16, sc, ss);
    if (sc <= 0) tanm = (ss == 0) ? 0 : 64'(TAN_MAX);
    else begin
      tanm = (mag(ss) << 16) / 64'(sc);
      if (tanm > 64'(TAN_MAX)) tanm = 64'(TAN_MAX);
    end
    bm = (mag(a) * 64'(inv_wb_q412) + (64'd1 << 19)) >> 20;
    cm = bm * tanm;
    dh = (cm >> 32) * 64'(RAD_TO_BAM)
       + (((cm & 64'hFFFFFFFF) * 64'(RAD_TO_BAM) + 64'h80000000) >> 32);
    dh = dh & 64'hFFFFFFFF;
    if ((a < 0) != (ss < 0)) dh = (-dh) & 64'hFFFFFFFF;
    pose_hdg = pose_hdg + dh[31:0];
    expected_pose.push_back('{pose_x, pose_y, pose_hdg});
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        euler_step('{req_ch.speed, req_ch.steer_angle});
        sent <= sent + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (drive_gap > 0) begin
          drive_gap <= drive_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_motion.size() > 0) begin
          if (!calm && $urandom_range(0, 5) == 0) begin
            drive_gap <= $urandom_range(1, 10);
            req_ch.valid <= 1'b0;
          end else begin
            req_ch.valid <= 1'b1;
            req_ch.speed <= pending_motion[0].speed;
            req_ch.steer_angle <= pending_motion[0].steer;
            void'(pending_motion.pop_front());
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        poses_seen <= poses_seen + 1;
        if (expected_pose.size() == 0) begin
          $error("unexpected pose x=%0d y=%0d heading=%0h",
                 res_ch.pos_x, res_ch.pos_y, res_ch.heading);
          errors = errors + 1;
        end else begin
          pose_t e;
          e = expected_pose.pop_front();
          if (res_ch.pos_x !== e.x) begin
            $error("pos_x expected %0d actual %0d", e.x, res_ch.pos_x);
            errors = errors + 1;
          end
          if (res_ch.pos_y !== e.y) begin
            $error("pos_y expected %0d actual %0d", e.y, res_ch.pos_y);
            errors = errors + 1;
          end
          if (res_ch.heading !== e.hdg) begin
            $error("heading expected %0h actual %0h", e.hdg, res_ch.heading);
            errors = errors + 1;
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        res_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        sink_gap <= $urandom_range(1, 10);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input reg_addr_t addr, input logic [15:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= addr; cfg_pwdata <= 32'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (addr == REG_TIME_STEP) dt_q016 = val;
    else inv_wb_q412 = val;
  endtask

  task automatic drain();
    while (pending_motion.size() > 0 || req_ch.valid || expected_pose.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic motion_t pick_motion();
    motion_t m;
    case ($urandom_range(0, 3))
      0: m.speed = 16'($urandom);
      1: m.speed = 16'($urandom_range(0, 2000) - 1000);
      2: m.speed = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: m.speed = 16'($urandom_range(0, 200) - 100);
    endcase
    m.steer = 15'($urandom);
    return m;
  endfunction

  initial begin
    logic [15:0] dts [5], wbs [5];
    dts = '{16'd6554, 16'd1, 16'd65535, 16'd300, 16'd0};
    wbs = '{16'd1638, 16'd65535, 16'd1, 16'd4096, 16'd0};
    dt_q016 = TIME_STEP_RST;
    inv_wb_q412 = INV_WB_RST;
    pose_x = 0; pose_y = 0; pose_hdg = 0;
    req_ch.valid = 1'b0; req_ch.speed = '0; req_ch.steer_angle = '0;
    res_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    pending_motion.push_back('{16'sd0, 15'sd0});
    pending_motion.push_back('{16'sh7FFF, 15'sd0});
    pending_motion.push_back('{16'sh8000, 15'sd0});
    pending_motion.push_back('{16'sh7FFF, 15'sh3FFF});
    pending_motion.push_back('{16'sh7FFF, 15'sh4000});
    pending_motion.push_back('{16'sh7FFF, 15'sh4001});
    pending_motion.push_back('{16'sh8000, 15'sh3FFF});
    pending_motion.push_back('{16'sd256, 15'sd8192});
    pending_motion.push_back('{-16'sd256, -15'sd8192});
    pending_motion.push_back('{16'sd1, 15'sd1});
    pending_motion.push_back('{-16'sd1, -15'sd1});
    pending_motion.push_back('{16'shAAAA, 15'sh2AAA});
    pending_motion.push_back('{16'sh5555, 15'sh5555});
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_TIME_STEP, dts[ph]);
      write_reg(REG_INV_WHEELBASE, wbs[(ph + 2) % 5]);
      for (int k = 0; k < 100; k++) pending_motion.push_back(pick_motion());
      drain();
    end
    write_reg(REG_TIME_STEP, 16'd65535);
    write_reg(REG_INV_WHEELBASE, 16'd65535);
    for (int k = 0; k < 150; k++) pending_motion.push_back('{16'sh7FFF, 15'sd0});
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_TIME_STEP, 16'($urandom_range(1, 65535)));
      write_reg(REG_INV_WHEELBASE, 16'($urandom_range(1, 65535)));
      if (ph == 3) calm = 1'b1;
      for (int k = 0; k < 250; k++) pending_motion.push_back(pick_motion());
      drain();
    end
    $display("Sent %0d requests over eleven register settings; %0d poses checked.",
             sent, poses_seen);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #80ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/bmps_pkg.sv
rtl/bmps_stream_if.sv
rtl/bicycle_model_pose_step.sv
verif/bicycle_model_pose_step_test.sv
